/* sv/ptdi_pkg.sv */
// Shared types, codes and constants of the period-tagged double inbox.
package ptdi_pkg;

    localparam int TASKS_DEFAULT         = 16;
    localparam int PAYLOAD_BYTES_DEFAULT = 8;

    localparam int TIME_W    = 64;
    localparam int PERIOD_W  = 32;
    localparam int DATA_W    = 64;
    localparam int IDX_MAX_W = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;
    localparam logic [TIME_W-1:0]   START_RESET  = 64'd0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Input action codes
    localparam logic [1:0] ACT_RECV = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DROP = 2'd0;
    localparam logic [1:0] ST_CUR  = 2'd1;
    localparam logic [1:0] ST_NEXT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 1'd1;

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] time_tag;
        logic signed [7:0] sender;
        logic              size_ok;
        logic [DATA_W-1:0] payload;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              entry_received;
        logic [DATA_W-1:0] entry_payload;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_STORE = 2'd1,
        OP_READ  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // Classified command handed from the front end to the back end
    typedef struct packed {
        op_t                  op;
        logic [1:0]           status;
        logic                 bank;
        logic                 idx_ok;
        logic [IDX_MAX_W-1:0] idx;
        logic [DATA_W-1:0]    data;
    } cmd_t;

endpackage

/* sv/ptdi_front.sv */
// Front end: owns period timing and bank selection, classifies each item.
module ptdi_front #(
    parameter int TASKS = ptdi_pkg::TASKS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ptdi_pkg::in_item_t                 in_data,
    input  logic                               cfg_valid,
    input  logic [ptdi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptdi_pkg::TIME_W-1:0]        cfg_data,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output ptdi_pkg::cmd_t                     cmd
);
    import ptdi_pkg::*;

    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [TIME_W-1:0]   base_reg, base_next;
    logic [TIME_W-1:0]   next_time_reg, next_time_next;
    logic                bank_reg, bank_next;
    logic                idx_ok;
    logic                push;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign push      = in_valid && cmd_ready;
    assign idx_ok    = !in_data.sender[7] && (in_data.sender[6:0] < IDX_MAX_W'(TASKS));

    always_comb
    begin
        cmd.op     = OP_NOP;
        cmd.status = ST_DROP;
        cmd.bank   = bank_reg;
        cmd.idx_ok = idx_ok;
        cmd.idx    = in_data.sender[6:0];
        cmd.data   = in_data.payload;
        case (in_data.action)
            ACT_RECV:
            begin
                if (in_data.size_ok && idx_ok)
                begin
                    if (in_data.time_tag == base_reg)
                    begin
                        cmd.op     = OP_STORE;
                        cmd.status = ST_CUR;
                    end
                    else if (in_data.time_tag == next_time_reg)
                    begin
                        cmd.op     = OP_STORE;
                        cmd.status = ST_NEXT;
                        cmd.bank   = ~bank_reg;
                    end
                end
            end
            ACT_READ:
            begin
                cmd.op     = OP_READ;
                cmd.status = ST_DONE;
            end
            ACT_TICK:
            begin
                cmd.op     = OP_TICK;
                cmd.status = ST_DONE;
            end
            default:
            begin
                cmd.op     = OP_NOP;
                cmd.status = ST_DROP;
            end
        endcase
    end

    // Keep the next period's base time precomputed so a tag needs only compares
    always_comb
    begin
        period_next    = period_reg;
        base_next      = base_reg;
        next_time_next = next_time_reg;
        bank_next      = bank_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PERIOD:
                begin
                    period_next    = cfg_data[PERIOD_W-1:0];
                    next_time_next = base_reg + TIME_W'(cfg_data[PERIOD_W-1:0]);
                end
                CFG_START:
                begin
                    base_next      = cfg_data;
                    next_time_next = cfg_data + TIME_W'(period_reg);
                end
                default:
                begin
                    period_next = period_reg;
                end
            endcase
        end
        else if (push && in_data.action == ACT_TICK)
        begin
            base_next      = next_time_reg;
            next_time_next = next_time_reg + TIME_W'(period_reg);
            bank_next      = ~bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            base_reg      <= START_RESET;
            next_time_reg <= START_RESET + TIME_W'(PERIOD_RESET);
            bank_reg      <= 1'b0;
        end
        else
        begin
            period_reg    <= period_next;
            base_reg      <= base_next;
            next_time_reg <= next_time_next;
            bank_reg      <= bank_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (push && in_data.action == ACT_TICK && !cfg_valid)
        |=> (base_reg == $past(next_time_reg) && bank_reg != $past(bank_reg)))
        else $error("tick did not advance base time and bank");
    a_next_time: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (next_time_reg == base_reg + TIME_W'(period_reg)))
        else $error("next base time out of step");
`endif

endmodule

/* sv/ptdi_queue.sv */
// Short command queue decoupling the front end from the back end.
module ptdi_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  ptdi_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ptdi_pkg::cmd_t pop_data
);
    import ptdi_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = q_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* sv/ptdi_back.sv */
// Back end: received flags, payload memory and the result pipeline.
module ptdi_back #(
    parameter int TASKS         = ptdi_pkg::TASKS_DEFAULT,
    parameter int PAYLOAD_BYTES = ptdi_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ptdi_pkg::cmd_t      cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output ptdi_pkg::out_item_t out_data
);
    import ptdi_pkg::*;

    localparam int PW     = 8 * PAYLOAD_BYTES;
    localparam int IDX_W  = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int ADDR_W = $clog2(2 * TASKS);
    localparam int DEPTH  = 2 * TASKS;

    logic [PW-1:0]    mem [DEPTH];
    logic [TASKS-1:0] flags_reg [2];
    logic [IDX_W-1:0] idx;
    logic [ADDR_W-1:0] addr;
    logic             pop;
    logic             s1_adv;

    logic             s1_valid_reg;
    logic [1:0]       s1_status_reg;
    logic             s1_rcv_reg;
    logic [PW-1:0]    rd_data_reg;

    logic             out_valid_reg;
    out_item_t        out_reg;

    assign idx  = cmd.idx[IDX_W-1:0];
    assign addr = cmd.bank ? (ADDR_W'(TASKS) + ADDR_W'(idx)) : ADDR_W'(idx);

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign cmd_ready = !s1_valid_reg || s1_adv;
    assign pop       = cmd_valid && cmd_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Payload memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (pop && cmd.op == OP_STORE)
        begin
            mem[addr] <= cmd.data[PW-1:0];
        end
        if (pop)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg[0] <= '0;
            flags_reg[1] <= '0;
        end
        else if (pop)
        begin
            case (cmd.op)
                OP_STORE: flags_reg[cmd.bank][idx] <= 1'b1;
                OP_TICK:  flags_reg[cmd.bank]      <= '0;
                default:  flags_reg[cmd.bank]      <= flags_reg[cmd.bank];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_status_reg <= ST_DROP;
            s1_rcv_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg  <= 1'b1;
                s1_status_reg <= cmd.status;
                s1_rcv_reg    <= (cmd.op == OP_READ) && cmd.idx_ok
                                 && flags_reg[cmd.bank][idx];
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (s1_adv)
            begin
                out_valid_reg          <= 1'b1;
                out_reg.status         <= s1_status_reg;
                out_reg.entry_received <= s1_rcv_reg;
                out_reg.entry_payload  <= s1_rcv_reg ? DATA_W'(rd_data_reg) : '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_rcv_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.entry_received) |-> (out_reg.status == ST_DONE))
        else $error("received flag reported outside a read");
    a_zero_when_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.entry_received) |-> (out_reg.entry_payload == '0))
        else $error("payload shown for an entry not received");
    a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.op == OP_TICK) |=> (flags_reg[$past(cmd.bank)] == '0))
        else $error("end of period left flags set");
`endif

endmodule

/* sv/period_tagged_double_inbox.sv */
// Top level of the period-tagged double inbox: front end, command queue, back end.
// Throughput: one item per cycle while out_ready is high; no item takes over one slot.
// Path: each accepted item passes the queue register, then the memory read register,
// then the output register, before its result is presented.
// Reset: asynchronous, active low; flags clear, bank 0, period 1000, base time 0.
// Payload memory is not cleared; entries are only ever returned behind a set flag.
module period_tagged_double_inbox #(
    parameter int TASKS         = ptdi_pkg::TASKS_DEFAULT,
    parameter int PAYLOAD_BYTES = ptdi_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ptdi_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ptdi_pkg::out_item_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ptdi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptdi_pkg::TIME_W-1:0]    cfg_data
);
    import ptdi_pkg::*;

    // Front end to queue
    logic f_valid;
    logic f_ready;
    cmd_t f_cmd;

    // Queue to back end
    logic b_valid;
    logic b_ready;
    cmd_t b_cmd;

    // Register writes go straight into the front-end registers, so always take them
    assign cfg_ready = 1'b1;

    // Classify each item against the current base time and bank; a tick with no
    // register write flips the bank so items behind it classify for the new period
    ptdi_front #(
        .TASKS (TASKS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    // Hold classified commands so either side may stall on its own
    ptdi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_cmd)
    );

    // Apply commands in order: set or clear flags, write or read the payload
    // memory, and deliver one result item per command
    ptdi_back #(
        .TASKS         (TASKS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd       (b_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
